>>> sv/utf8_stream_decoder_macros.svh
// Assertion helpers for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Check under clock, skipped while reset is high.
`define UTF8D_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utf8d check failed");
// Check under clock, active during reset too.
`define UTF8D_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("utf8d check failed");
`else
`define UTF8D_ASSERT(label, clk, rst, prop)
`define UTF8D_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> sv/utf8d_pkg.sv
package utf8d_pkg;

   // Byte constants
   localparam logic [7:0] LEAD_MARK    = 8'd128;
   localparam logic [7:0] BYTE_MASK    = 8'hff;
   localparam logic [7:0] PAYLOAD_MASK = 8'd63;

   // Result status codes
   localparam logic [1:0] ST_CHAR  = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // Decoder state carried between bytes
   typedef struct packed {
      logic [2:0]  bytes_left;
      logic [3:0]  seq_length;
      logic [31:0] accumulator;
   } dec_state_type;

   // One decoded result
   typedef struct packed {
      logic        emit;
      logic [31:0] code_point;
      logic [1:0]  status;
      logic [3:0]  bytes_used;
   } dec_result_type;

endpackage

>>> sv/utf8d_step.sv
module utf8d_step (
   input  logic [7:0]               text_byte,
   input  utf8d_pkg::dec_state_type state_cur,
   output utf8d_pkg::dec_state_type state_nxt,
   output utf8d_pkg::dec_result_type result
);
   import utf8d_pkg::*;

   // Count leading one bits of a byte, 0 to 8
   function automatic logic [3:0] lead_count(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   logic [3:0]  n_ones;
   logic [7:0]  lead_bits;
   logic [31:0] acc_shift;
   logic [2:0]  left_dec;
   logic [3:0]  taken;

   assign n_ones    = lead_count(text_byte);
   assign lead_bits = text_byte & (BYTE_MASK >> n_ones);
   assign acc_shift = {state_cur.accumulator[25:0], 6'b0}
                    | {24'd0, text_byte & PAYLOAD_MASK};
   assign left_dec  = state_cur.bytes_left - 3'd1;
   assign taken     = state_cur.seq_length - {1'b0, state_cur.bytes_left} + 4'd1;

   // Advance the decoder by one byte
   always_comb begin
      state_nxt         = state_cur;
      result.emit       = 1'b0;
      result.code_point = 32'd0;
      result.status     = ST_CHAR;
      result.bytes_used = 4'd1;
      if (state_cur.bytes_left == 3'd0) begin
         if (text_byte == 8'd0) begin
            result.emit   = 1'b1;
            result.status = ST_END;
         end else if ((text_byte & LEAD_MARK) == 8'd0) begin
            result.emit       = 1'b1;
            result.code_point = {24'd0, text_byte};
         end else if (n_ones == 4'd1) begin
            result.emit           = 1'b1;
            result.code_point     = {24'd0, lead_bits};
            state_nxt.accumulator = 32'd0;
         end else begin
            state_nxt.accumulator = {24'd0, lead_bits};
            state_nxt.seq_length  = n_ones;
            state_nxt.bytes_left  = n_ones[2:0] - 3'd1;
         end
      end else if (text_byte == 8'd0) begin
         result.emit       = 1'b1;
         result.status     = ST_TRUNC;
         result.bytes_used = taken;
         state_nxt         = '0;
      end else if (left_dec == 3'd0) begin
         result.emit       = 1'b1;
         result.code_point = acc_shift;
         result.bytes_used = state_cur.seq_length;
         state_nxt         = '0;
      end else begin
         state_nxt.accumulator = acc_shift;
         state_nxt.bytes_left  = left_dec;
      end
   end

endmodule

>>> sv/utf8_stream_decoder.sv
// UTF-8 stream decoder: one text byte in per transfer, at most one code point out.
// Path: the byte transfer loads the input register, then one decode step writes the
// result register, which drives the result transfer.
// Throughput: 1 byte per cycle, set by the single decode step between the registers;
// a result held while rsp_ready is low stalls the input.
// Reset (synchronous, active high) clears both valid flags and the decoder state.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_code_point,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_bytes_used
);
   import utf8d_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   dec_state_type  state_ff, state_in;
   dec_state_type  step_state;
   dec_result_type step_result;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_code_ff;
   logic [1:0]     out_status_ff;
   logic [3:0]     out_used_ff;
   logic           rsp_free;
   logic           fire;

   utf8d_step u_step (
      .text_byte (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (step_state),
      .result    (step_result)
   );

   // Process the held byte whenever the result register can take a result
   assign rsp_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && rsp_free;
   assign req_ready = !in_valid_ff || fire;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign state_in     = fire ? step_state : state_ff;
   assign out_valid_in = fire ? step_result.emit : (out_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: capture byte on transfer, result on a decode step that emits
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
      end
      if (fire && step_result.emit) begin
         out_code_ff   <= step_result.code_point;
         out_status_ff <= step_result.status;
         out_used_ff   <= step_result.bytes_used;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_code_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_bytes_used = out_used_ff;

   // Mid-sequence state keeps a length longer than the bytes still due
   `UTF8D_ASSERT(a_seq_len, clock, reset,
      (state_ff.bytes_left != 3'd0) |->
      (state_ff.seq_length > {1'b0, state_ff.bytes_left}))
   // Idle state holds no partial character
   `UTF8D_ASSERT_ALWAYS(a_idle_clear, clock,
      (state_ff.bytes_left == 3'd0) |->
      (state_ff.seq_length == 4'd0 && state_ff.accumulator == 32'd0))
   // A new result only follows a decode step on a held byte
   `UTF8D_ASSERT(a_rsp_source, clock, reset,
      (out_valid_ff && !$past(out_valid_ff)) |-> $past(in_valid_ff))
   // End of text carries zero value and one byte
   `UTF8D_ASSERT(a_end_form, clock, reset,
      (out_valid_ff && out_status_ff == ST_END) |->
      (out_code_ff == 32'd0 && out_used_ff == 4'd1))

endmodule

>>> verif/code_point_tracker_pkg.sv
`timescale 1ns / 100ps

package code_point_tracker_pkg;

   import utf8d_pkg::*;

   // One expected decoder result
   typedef struct packed {
      logic [31:0] code_point;
      logic [1:0]  status;
      logic [3:0]  bytes_used;
   } char_result_type;

   // Tracks the decoder state for every byte transfer and matches result transfers
   class code_point_tracker;
      logic [2:0]      left_count;
      logic [3:0]      char_length;
      logic [31:0]     partial_value;
      char_result_type pending_chars[$];
      int unsigned     error_count;

      function new();
         left_count    = '0;
         char_length   = '0;
         partial_value = '0;
         error_count   = 0;
      endfunction

      function int unsigned pending();
         return pending_chars.size();
      endfunction

      function void queue_char(logic [31:0] cp, logic [1:0] st, logic [3:0] used);
         char_result_type r;
         r.code_point = cp;
         r.status     = st;
         r.bytes_used = used;
         pending_chars.push_back(r);
      endfunction

      // Count the run of one bits from the top of the lead byte
      function int unsigned lead_ones(logic [7:0] b);
         int unsigned n;
         n = 0;
         for (int i = 7; i >= 0; i--) begin
            if (!b[i])
               break;
            n++;
         end
         return n;
      endfunction

      // Advance the decoder state by one accepted byte
      function void take_byte(logic [7:0] b);
         int unsigned n;
         logic [3:0]  taken;
         if (left_count == 3'd0) begin
            if (b == 8'h00) begin
               queue_char(32'd0, ST_END, 4'd1);
            end else if ((b & LEAD_MARK) == 8'h00) begin
               queue_char({24'd0, b}, ST_CHAR, 4'd1);
            end else begin
               n = lead_ones(b);
               partial_value = {24'd0, b & (BYTE_MASK >> n)};
               if (n == 1) begin
                  queue_char(partial_value, ST_CHAR, 4'd1);
                  partial_value = '0;
               end else begin
                  char_length = 4'(n);
                  left_count  = 3'(n - 1);
               end
            end
         end else if (b == 8'h00) begin
            // zero inside a sequence: truncate and drop back to idle
            taken = char_length - {1'b0, left_count} + 4'd1;
            left_count    = '0;
            char_length   = '0;
            partial_value = '0;
            queue_char(32'd0, ST_TRUNC, taken);
         end else begin
            // shift in six payload bits, wrapping at 32 bits
            partial_value = {partial_value[25:0], 6'(b & PAYLOAD_MASK)};
            left_count = left_count - 3'd1;
            if (left_count == 3'd0) begin
               queue_char(partial_value, ST_CHAR, char_length);
               char_length   = '0;
               partial_value = '0;
            end
         end
      endfunction

      // Compare one result transfer against the oldest expected result
      function void match_result(logic [31:0] cp, logic [1:0] st, logic [3:0] used);
         char_result_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected result: code_point %0h status %0d bytes_used %0d",
                   cp, st, used);
            error_count++;
            return;
         end
         want = pending_chars.pop_front();
         if (cp !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, cp);
            error_count++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            error_count++;
         end
         if (used !== want.bytes_used) begin
            $error("bytes_used: expected %0d, got %0d", want.bytes_used, used);
            error_count++;
         end
      endfunction
   endclass

endpackage

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

   import utf8d_pkg::*;
   import code_point_tracker_pkg::*;

   localparam int unsigned BYTE_TARGET = 1450;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_code_point;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_bytes_used;

   code_point_tracker tracker = new();

   int unsigned bytes_sent = 0;
   logic        calm = 1'b0;

   logic        rsp_seen = 1'b0;
   logic [31:0] seen_code_point;
   logic [1:0]  seen_status;
   logic [3:0]  seen_bytes_used;

   utf8_stream_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status),
      .rsp_bytes_used (rsp_bytes_used)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the decoder hangs
   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // Sample the result channel away from the active edge
   always @(negedge clock) begin
      rsp_seen        = !reset && rsp_valid && rsp_ready;
      seen_code_point = rsp_code_point;
      seen_status     = rsp_status;
      seen_bytes_used = rsp_bytes_used;
   end

   // Check each result transfer and stall the result side at random
   always @(posedge clock) begin
      if (rsp_seen)
         tracker.match_result(seen_code_point, seen_status, seen_bytes_used);
      rsp_ready <= calm || ($urandom_range(99) >= 9);
   end

   // Drive one byte and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      logic got;
      calm = (bytes_sent >= 600) && (bytes_sent < 1000);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do begin
         @(negedge clock);
         got = req_ready;
         @(posedge clock);
      end while (!got);
      tracker.take_byte(b);
      bytes_sent++;
   endtask

   // Lead byte with n leading ones and random payload bits below the marker zero
   function automatic logic [7:0] lead_byte(int unsigned n);
      logic [7:0] prefix;
      logic [7:0] body;
      prefix = 8'hff << (8 - n);
      body   = 8'($urandom) & (8'hff >> (n + 1));
      return prefix | body;
   endfunction

   // Mostly proper continuation bytes, sometimes any nonzero byte
   function automatic logic [7:0] tail_byte();
      if ($urandom_range(99) < 90)
         return {2'b10, 6'($urandom)};
      return 8'($urandom_range(255, 1));
   endfunction

   task automatic send_sequence(int unsigned n, int unsigned tails);
      send_byte(lead_byte(n));
      for (int unsigned i = 0; i < tails; i++)
         send_byte(tail_byte());
   endtask

   initial begin
      int unsigned roll;
      int unsigned n;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // End of text, ASCII extremes, lone leads
      send_byte(8'h00);
      send_byte(8'h41);
      send_byte(8'h7f);
      send_byte(8'h80);
      send_byte(8'hbf);
      // Two, three and four byte characters
      send_byte(8'hc3);
      send_byte(8'ha9);
      send_byte(8'he2);
      send_byte(8'h82);
      send_byte(8'hac);
      send_byte(8'hf0);
      send_byte(8'h9f);
      send_byte(8'h98);
      send_byte(8'h80);
      // Eight-byte lead with unchecked prefixes; value wraps past 32 bits
      send_byte(8'hff);
      repeat (7) send_byte(8'hff);
      // Zero inside a sequence
      send_byte(8'he2);
      send_byte(8'h00);

      // Random part: mostly well-formed characters, some truncated, some noise
      while (bytes_sent < BYTE_TARGET) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            roll = $urandom_range(99);
            if (roll < 25)      n = 0;
            else if (roll < 35) n = 1;
            else if (roll < 55) n = 2;
            else if (roll < 70) n = 3;
            else if (roll < 85) n = 4;
            else                n = $urandom_range(8, 5);
            send_sequence(n, (n > 1) ? n - 1 : 0);
         end else if (roll < 85) begin
            n = $urandom_range(8, 2);
            send_sequence(n, $urandom_range(n - 2, 0));
            send_byte(8'h00);
         end else if (roll < 88) begin
            send_byte(8'h00);
         end else begin
            send_byte(8'($urandom_range(255, 0)));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain outstanding results, then allow the pipeline to settle
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (tracker.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> utf8_stream_decoder.f
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_stream_decoder.sv
verif/code_point_tracker_pkg.sv
verif/tb.sv
